// ----- rtl/sml_pkg.sv -----
// ----------------------------------------------------------------------------
// sml_pkg: shared constants and types for the substring match locator
// Window depth, field widths, register indexes and the text byte type.
// ----------------------------------------------------------------------------
package sml_pkg;

  localparam int MAX_PATTERN  = 8;
  localparam int POS_W        = 16;  // width of the byte and match counters
  localparam int FIELD_W      = 16;  // width of the position/count fields
  localparam int BYTE_W       = 8;
  localparam int PAT_LEN_W    = $clog2(MAX_PATTERN + 1) > 4 ? $clog2(MAX_PATTERN + 1) : 4;
  localparam int PAT_IDX_W    = MAX_PATTERN > 1 ? $clog2(MAX_PATTERN) : 1;
  localparam int PAT_W        = MAX_PATTERN * BYTE_W;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'd1;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- rtl/sml_text_if.sv -----
// ----------------------------------------------------------------------------
// sml_text_if: text byte channel
// Valid/ready channel carrying one text byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface sml_text_if;
  import sml_pkg::*;

  logic  valid;
  logic  ready;
  byte_t text_byte;
  logic  end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);

endinterface

// ----- rtl/sml_result_if.sv -----
// ----------------------------------------------------------------------------
// sml_result_if: match result channel
// Valid/ready channel carrying one match or end-of-text result.
// ----------------------------------------------------------------------------
interface sml_result_if;
  import sml_pkg::*;

  logic               valid;
  logic               ready;
  logic               match_found;
  logic [FIELD_W-1:0] start_position;
  logic               text_done;
  logic [FIELD_W-1:0] match_count;

  modport source (output valid, output match_found, output start_position,
                  output text_done, output match_count, input ready);
  modport sink   (input valid, input match_found, input start_position,
                  input text_done, input match_count, output ready);

endinterface

// ----- rtl/sml_cell.sv -----
// ----------------------------------------------------------------------------
// sml_cell: one window slot of the search chain
// Holds one text byte, passes it on at each shift and compares the byte
// entering the slot against its pattern character.
// ----------------------------------------------------------------------------
module sml_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  sml_pkg::byte_t byte_in,
  input  sml_pkg::byte_t pat_byte,
  input  logic          active,
  output sml_pkg::byte_t byte_q,
  output logic          eq
);
  import sml_pkg::*;

  // Compare against the byte that lands here on this shift; an unused
  // slot never blocks a match.
  assign eq = !active || (byte_in == pat_byte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= byte_in;
    end
  end

endmodule

// ----- rtl/substring_match_locator.sv -----
// ----------------------------------------------------------------------------
// substring_match_locator: streaming all-occurrence pattern search
// Throughput: one text byte per cycle while the result sink keeps up; the
// result is registered and shows in the cycle after its byte is accepted.
// Window compare and counters settle in the accept cycle (chain of 8 cells).
// Reset (sync, active high) clears counters, pattern registers, result valid.
module substring_match_locator (
  input  logic                          clk,
  input  logic                          rst,
  sml_text_if.sink                      text,
  sml_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [sml_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sml_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sml_pkg::*;

  // Configuration registers
  logic [PAT_W-1:0]     pattern;
  logic [PAT_LEN_W-1:0] pat_len;

  // Per-text state
  logic [POS_W-1:0] bytes_seen;
  logic [POS_W-1:0] match_cnt;
  logic [POS_W-1:0] seen_next;
  logic [POS_W-1:0] match_cnt_next;
  logic [POS_W-1:0] start_calc;

  // Output register
  logic               res_valid;
  logic               res_match;
  logic [FIELD_W-1:0] res_start;
  logic               res_done;
  logic [FIELD_W-1:0] res_count;

  logic accept;
  logic len_ok;
  logic hit;
  logic emit;

  byte_t                  chain  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_eq;

  // Input is taken whenever the output register is empty or draining this
  // cycle, so bytes stream back to back.
  assign text.ready = !res_valid || result.ready;
  assign accept     = text.valid && text.ready;

  // --------------------------------------------------------------------------
  // Cell chain. Slot 0 sees the incoming byte, slot j the byte that was j
  // transactions ago. Slot j is checked against pattern char len-1-j, so the
  // newest byte lines up with the last pattern character.
  // --------------------------------------------------------------------------
  assign chain[0] = text.text_byte;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [PAT_IDX_W-1:0] pat_idx;
    byte_t                pat_byte;
    logic                 active;

    assign pat_idx  = PAT_IDX_W'(pat_len - PAT_LEN_W'(j) - PAT_LEN_W'(1));
    assign pat_byte = pattern[pat_idx*BYTE_W +: BYTE_W];
    assign active   = PAT_LEN_W'(j) < pat_len;

    if (j < MAX_PATTERN - 1) begin : g_mid
      sml_cell u_cell (
        .clk      (clk),
        .shift_en (accept),
        .byte_in  (chain[j]),
        .pat_byte (pat_byte),
        .active   (active),
        .byte_q   (chain[j+1]),
        .eq       (cell_eq[j])
      );
    end else begin : g_end
      // Tail slot: its byte drops out of the window on the next shift.
      sml_cell u_cell (
        .clk      (clk),
        .shift_en (accept),
        .byte_in  (chain[j]),
        .pat_byte (pat_byte),
        .active   (active),
        .byte_q   (),
        .eq       (cell_eq[j])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Match decision and counters
  // --------------------------------------------------------------------------
  assign seen_next = (bytes_seen == POS_MAX) ? bytes_seen : bytes_seen + POS_W'(1);

  // Zero or overlong length never matches; bytes_seen guard keeps stale
  // window bytes from an earlier text out of the compare.
  assign len_ok = (pat_len != '0) && (pat_len <= PAT_LEN_W'(MAX_PATTERN));
  assign hit    = len_ok && (seen_next >= POS_W'(pat_len)) && (&cell_eq);
  assign emit   = hit || text.end_of_text;

  assign start_calc     = seen_next - POS_W'(pat_len) + POS_W'(1);
  assign match_cnt_next = (hit && match_cnt != POS_MAX) ? match_cnt + POS_W'(1) : match_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern <= '0;
      pat_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:  pattern <= cfg_data[PAT_W-1:0];
        REG_PATTERN_LENGTH: pat_len <= cfg_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_cnt  <= '0;
    end else if (accept) begin
      if (text.end_of_text) begin
        // end of text: restart position and count for the next one
        bytes_seen <= '0;
        match_cnt  <= '0;
      end else begin
        bytes_seen <= seen_next;
        match_cnt  <= match_cnt_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: loaded only by bytes that match or end the text.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_match <= hit;
      res_start <= hit ? FIELD_W'(start_calc) : '0;
      res_done  <= text.end_of_text;
      res_count <= FIELD_W'(match_cnt_next);
    end
  end

  assign result.valid          = res_valid;
  assign result.match_found    = res_match;
  assign result.start_position = res_start;
  assign result.text_done      = res_done;
  assign result.match_count    = res_count;

`ifndef ASSERT_OFF
  // A result carrying no match must be an end-of-text result.
  a_nomatch_is_done: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.match_found |-> result.text_done)
    else $error("result with no match and no end of text");

  // A reported match has a nonzero start and a nonzero count.
  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.match_found |->
      result.start_position != '0 && result.match_count != '0)
    else $error("match result with zero start or count");

  // End of text restarts the per-text counters.
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    accept && text.end_of_text |=> bytes_seen == '0 && match_cnt == '0)
    else $error("counters not cleared after end of text");

  // Reset leaves no result pending and empty counters.
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> !res_valid && bytes_seen == '0 && match_cnt == '0)
    else $error("state not cleared by reset");
`endif

endmodule

// ----- tb/sv/tb_substring_match_locator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_substring_match_locator: self-checking bench for the pattern locator
// A directed table covers reset state, zero/full/overlong pattern lengths,
// short texts and overlaps. Random texts that are rich in pattern bytes then
// run under several idle mixes, a long sink hold-off and a sender pause.
// Every result is checked against a typed-in value or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_substring_match_locator;
  import sml_pkg::*;

  localparam int CLK_PERIOD  = 12;
  localparam int RESET_LEN   = 4;
  localparam int DRAIN_GAP   = 4;       // margin past the block's result register
  localparam int CYCLE_LIMIT = 600000;  // watchdog limit on the whole run
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 135;
  localparam int HOLD_CYCLES = 300;     // long sink hold-off to back up the block

  // One result transaction as it leaves the block
  typedef struct packed {
    logic               match_found;
    logic [FIELD_W-1:0] start_position;
    logic               text_done;
    logic [FIELD_W-1:0] match_count;
  } locate_result_t;

  typedef enum logic [1:0] {ROW_TEXT, ROW_SET_PATTERN, ROW_SET_LENGTH} row_kind_e;

  // Directed stimulus row; fixed=1 means the expected result is typed in
  typedef struct packed {
    row_kind_e         kind;
    logic [63:0]       data;
    byte_t             tbyte;
    logic              eot;
    logic              fixed;
    locate_result_t    want;
  } dir_row_t;

  localparam locate_result_t NO_RESULT     = '0;
  localparam locate_result_t DONE_NO_MATCH = '{1'b0, 16'd0, 1'b1, 16'd0};

  localparam dir_row_t DIRECTED_ROWS [26] = '{
    // reset state: length 0 never matches, end of text still reports
    '{ROW_TEXT,        64'h0, 8'h00, 1'b1, 1'b1, DONE_NO_MATCH},
    // length 1 against the reset pattern (all zero)
    '{ROW_SET_LENGTH,  64'd1, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h00, 1'b0, 1'b1, '{1'b1, 16'd1, 1'b0, 16'd1}},
    '{ROW_TEXT,        64'h0, 8'h00, 1'b1, 1'b1, '{1'b1, 16'd2, 1'b1, 16'd2}},
    // short text: cleared window zeros must not complete a length-3 match
    '{ROW_SET_LENGTH,  64'd3, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h00, 1'b1, 1'b1, DONE_NO_MATCH},
    // full-length all-ones pattern, match lands on the last byte
    '{ROW_SET_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd8, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b1, 1'b1, '{1'b1, 16'd1, 1'b1, 16'd1}},
    // overlong lengths (9 and 15), upper data bits set and dropped
    '{ROW_SET_LENGTH,  64'hFFFF_FFFF_FFFF_FFF9, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b1, 1'b1, DONE_NO_MATCH},
    '{ROW_SET_LENGTH,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'hFF, 1'b1, 1'b1, DONE_NO_MATCH},
    // overlapping matches of "aa" in "aaa"
    '{ROW_SET_PATTERN, 64'h0000_0000_0000_6161, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_SET_LENGTH,  64'd2, 8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h61, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h61, 1'b0, 1'b0, NO_RESULT},
    '{ROW_TEXT,        64'h0, 8'h61, 1'b1, 1'b0, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sml_text_if   text_ch ();
  sml_result_if result_ch ();

  substring_match_locator dut (
    .clk       (clk),
    .rst       (rst),
    .text      (text_ch.sink),
    .result    (result_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: window newest byte in bits 7:0, counters, registers
  logic [PAT_W-1:0]     window_bits = '0;
  logic [POS_W-1:0]     text_len    = '0;
  logic [POS_W-1:0]     hit_total   = '0;
  logic [PAT_W-1:0]     pat_reg     = '0;
  logic [PAT_LEN_W-1:0] pat_len_reg = '0;

  locate_result_t pending_results [$];

  int src_idle_pct  = 0;   // chance (in %) that the sender idles a cycle
  int sink_stall_pct = 0;  // chance (in %) that the sink drops ready
  int hold_req      = 0;   // hold-off request, picked up by the sink process
  int fail_count    = 0;
  int results_seen  = 0;
  int bytes_sent    = 0;
  int texts_sent    = 0;
  int reg_writes    = 0;
  int cycle_count   = 0;

  // Next-state and result for one text byte; returns 1 if a result is due
  function automatic bit predict_text_byte(input byte_t b, input bit eot,
                                           output locate_result_t res);
    bit hit;
    logic [POS_W-1:0] start;
    int k;
    window_bits = {window_bits[PAT_W-BYTE_W-1:0], b};
    if (text_len != POS_MAX) text_len++;
    hit = (pat_len_reg != 0) && (pat_len_reg <= MAX_PATTERN) && (text_len >= pat_len_reg);
    if (hit) begin
      // pattern char k sits pat_len-1-k bytes back from the newest byte
      for (k = 0; k < pat_len_reg; k++) begin
        if (window_bits[8*(pat_len_reg-1-k) +: 8] != pat_reg[8*k +: 8]) hit = 1'b0;
      end
    end
    start = '0;
    if (hit) begin
      start = text_len - POS_W'(pat_len_reg) + 1'b1;
      if (hit_total != POS_MAX) hit_total++;
    end
    res = '{hit, start, eot, hit_total};
    if (eot) begin
      window_bits = '0;
      text_len    = '0;
      hit_total   = '0;
    end
    return hit || eot;
  endfunction

  // Offer one text transaction; valid stays up on return so a following
  // item can go back to back
  task automatic push_text(input byte_t b, input bit eot, input bit fixed,
                           input locate_result_t want);
    locate_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.end_of_text <= eot;
    @(posedge clk);
    while (text_ch.ready !== 1'b1) @(posedge clk);
    bytes_sent++;
    if (eot) texts_sent++;
    if (predict_text_byte(b, eot, res) && !fixed) pending_results.push_back(res);
    if (fixed) pending_results.push_back(want);
  endtask

  // Drop valid and let one edge pass so the next raise is in a later step
  task automatic text_stop();
    text_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then cover the block's latency
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // Register write; only called with nothing in flight
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PATTERN_BYTES) pat_reg = data;
    else pat_len_reg = data[PAT_LEN_W-1:0];
    reg_writes++;
    @(posedge clk);
  endtask

  // Random texts built mostly from pattern bytes: whole copies, broken
  // prefixes and single pattern chars, with plain noise mixed in. The last
  // text may be left open so the next setting lands mid-text.
  task automatic run_texts(input int n_items, input bit may_leave_open);
    byte_t txt [$];
    int sent;
    int len;
    int r;
    int k;
    int cut;
    int plen_eff;
    bit leave_open;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 80) len = $urandom_range(24, 1);
      else if (r < 95) len = $urandom_range(80, 25);
      else len = $urandom_range(200, 81);
      // keep the phase at its item budget
      if (len > n_items - sent) len = n_items - sent;
      plen_eff = (pat_len_reg >= 1 && pat_len_reg <= MAX_PATTERN) ?
                 int'(pat_len_reg) : $urandom_range(MAX_PATTERN, 1);
      txt.delete();
      while (txt.size() < len) begin
        r = $urandom_range(99);
        if (r < 25) begin
          for (k = 0; k < plen_eff; k++) txt.push_back(pat_reg[8*k +: 8]);
        end else if (r < 35) begin
          cut = $urandom_range(plen_eff - 1, 0);
          for (k = 0; k < cut; k++) txt.push_back(pat_reg[8*k +: 8]);
        end else if (r < 75) begin
          txt.push_back(pat_reg[8*$urandom_range(plen_eff - 1, 0) +: 8]);
        end else begin
          txt.push_back(byte_t'($urandom_range(255)));
        end
      end
      leave_open = may_leave_open && (sent + len >= n_items) && ($urandom_range(2) == 0);
      for (k = 0; k < len; k++) begin
        push_text(txt[k], (k == len - 1) && !leave_open, 1'b0, NO_RESULT);
      end
      sent += len;
    end
    text_stop();
  endtask

  // Sink: checks every accepted result, then picks ready for the next edge.
  // A hold-off request is counted down here, cycle by cycle.
  initial begin : result_sink
    int hold_left;
    locate_result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: found=%0b pos=%0d done=%0b count=%0d",
                 result_ch.match_found, result_ch.start_position,
                 result_ch.text_done, result_ch.match_count);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_ch.match_found !== want.match_found) begin
            $error("match_found: expected %0b, got %0b", want.match_found,
                   result_ch.match_found);
            fail_count++;
          end
          if (result_ch.start_position !== want.start_position) begin
            $error("start_position: expected %0d, got %0d", want.start_position,
                   result_ch.start_position);
            fail_count++;
          end
          if (result_ch.text_done !== want.text_done) begin
            $error("text_done: expected %0b, got %0b", want.text_done,
                   result_ch.text_done);
            fail_count++;
          end
          if (result_ch.match_count !== want.match_count) begin
            $error("match_count: expected %0d, got %0d", want.match_count,
                   result_ch.match_count);
            fail_count++;
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int p;
    int r;
    int k;
    logic [63:0] pat_word;
    logic [63:0] len_word;
    byte_t ch_x;
    byte_t ch_y;

    // every block input known from time zero
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_PATTERN_BYTES;
    cfg_data            <= '0;
    text_ch.valid       <= 1'b0;
    text_ch.text_byte   <= '0;
    text_ch.end_of_text <= 1'b0;
    result_ch.ready     <= 1'b0;
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; register rows wait for the block to go quiet
    foreach (DIRECTED_ROWS[i]) begin
      case (DIRECTED_ROWS[i].kind)
        ROW_TEXT: begin
          push_text(DIRECTED_ROWS[i].tbyte, DIRECTED_ROWS[i].eot,
                    DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
        end
        ROW_SET_PATTERN: begin
          text_stop();
          wait_drained();
          cfg_write(REG_PATTERN_BYTES, DIRECTED_ROWS[i].data);
        end
        default: begin
          text_stop();
          wait_drained();
          cfg_write(REG_PATTERN_LENGTH, DIRECTED_ROWS[i].data);
        end
      endcase
    end
    text_stop();

    // Random phases: idle mix rotates none / sender / sink / both
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      if ($urandom_range(1) == 0) begin
        // two-letter pattern so overlaps turn up often
        ch_x = byte_t'($urandom_range(255));
        ch_y = byte_t'($urandom_range(255));
        for (k = 0; k < MAX_PATTERN; k++) pat_word[8*k +: 8] = $urandom_range(1) ? ch_x : ch_y;
      end else begin
        pat_word = {$urandom(), $urandom()};
      end
      len_word = ($urandom_range(1) == 0) ? {$urandom(), $urandom()} : 64'd0;
      r = $urandom_range(99);
      if (r < 10) len_word[PAT_LEN_W-1:0] = '0;
      else if (r < 20) len_word[PAT_LEN_W-1:0] = PAT_LEN_W'($urandom_range(15, MAX_PATTERN + 1));
      else len_word[PAT_LEN_W-1:0] = PAT_LEN_W'($urandom_range(MAX_PATTERN, 1));
      cfg_write(REG_PATTERN_BYTES, pat_word);
      cfg_write(REG_PATTERN_LENGTH, len_word);

      case (p % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 53; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 53; end
        default: begin src_idle_pct = 11; sink_stall_pct = 11; end
      endcase

      if (p == 4) begin
        // sink holds off while the sender keeps offering: input must stall
        hold_req = HOLD_CYCLES;
        run_texts(PHASE_ITEMS, 1'b1);
      end else if (p == 5) begin
        // sender pauses mid-phase until every result is back
        run_texts(PHASE_ITEMS / 2, 1'b0);
        while (pending_results.size() != 0) @(posedge clk);
        run_texts(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
      end else begin
        run_texts(PHASE_ITEMS, 1'b1);
      end
    end

    wait_drained();
    $display("Run covered %0d text bytes in %0d texts, %0d register writes, %0d results.",
             bytes_sent, texts_sent, reg_writes, results_seen);
    $display("Idle mixes, a long sink hold-off and a sender pause all ran.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sml_pkg.sv
rtl/sml_text_if.sv
rtl/sml_result_if.sv
rtl/sml_cell.sv
rtl/substring_match_locator.sv
tb/sv/tb_substring_match_locator.sv
